>>> rtl/kemu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Kruskal edge merge unit - shared package
// Beat types, controller states, command/status bundles and default sizes.
// ----------------------------------------------------------------------------
package kemu_pkg;

  // Default sizes
  localparam int MAX_NODES_DEF   = 128;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed field widths
  localparam int NODE_FIELD_W   = 8;
  localparam int WEIGHT_FIELD_W = 16;
  localparam int SUM_W          = 23;

  localparam logic [SUM_W-1:0]        SUM_MAX        = '1;
  localparam logic [NODE_FIELD_W-1:0] NODE_COUNT_RST = 8'd128;

  // Input beat: one graph edge
  typedef struct packed {
    logic [NODE_FIELD_W-1:0]   node_a;
    logic [NODE_FIELD_W-1:0]   node_b;
    logic [WEIGHT_FIELD_W-1:0] weight;
    logic                      last_edge;
  } in_beat_t;

  // Output beat: one result per edge
  typedef struct packed {
    logic             selected;
    logic [SUM_W-1:0] total_weight;
    logic             complete;
    logic             failed;
  } out_beat_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK_A,
    ST_LOOK_B,
    ST_COMPARE,
    ST_SWEEP,
    ST_FINISH
  } kemu_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // load the incoming edge
    logic look_a;    // read label of node_a
    logic look_b;    // read label of node_b, capture label of node_a
    logic compare;   // capture label of node_b, decide on merge
    logic sweep;     // one relabel step
    logic finish;    // commit totals and load result
    logic init;      // one label initialisation step
  } kemu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic eligible;    // edge ends in range and tree still open
    logic differ;      // the two ends carry different labels
    logic sweep_done;  // relabel sweep on its final check
    logic init_done;   // label initialisation on its final entry
    logic out_free;    // result register can take a new beat
    logic last_edge;   // held edge closes the graph
  } kemu_sts_t;

endpackage
`default_nettype wire

>>> rtl/kruskal_edge_merge_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: an edge with an end out of range or after completion goes from ST_LOOK_A to ST_FINISH;
//   one whose ends share a label passes ST_LOOK_B and ST_COMPARE; a selected edge also runs the
//   relabel sweep over the label RAM (one entry per cycle). ST_FINISH waits for a free result
//   register. One edge at a time; a last edge adds a label initialisation pass with in_stall high.
// Reset (synchronous, rst_n low): node_count 128, then a label pass with in_stall high.
//   A node_count write starts the same pass over the new node count.
// ----------------------------------------------------------------------------
// Kruskal edge merge unit - top level
// Sorted edge stream in, per-edge merge result out, union by label relabelling.
// ----------------------------------------------------------------------------
module kruskal_edge_merge_unit_core #(
  parameter int MAX_NODES   = kemu_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = kemu_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire kemu_pkg::in_beat_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output kemu_pkg::out_beat_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [kemu_pkg::NODE_FIELD_W-1:0] cfg_wdata
);

  import kemu_pkg::*;

  kemu_cmd_t cmd;
  kemu_sts_t sts;

  kemu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .cfg_we   (cfg_we),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  kemu_dp #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> rtl/kemu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Kruskal edge merge unit - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kemu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/kemu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Kruskal edge merge unit - controller
// Sequences label lookups, the relabel sweep, result commit and label init.
// ----------------------------------------------------------------------------
module kemu_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                cfg_we,
  input  wire kemu_pkg::kemu_sts_t sts,
  output logic                     in_stall,
  output kemu_pkg::kemu_cmd_t      cmd
);

  import kemu_pkg::*;

  kemu_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_INIT: begin
        cmd.init = 1'b1;
        if (sts.init_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_LOOK_A;
        end
      end
      ST_LOOK_A: begin
        cmd.look_a = 1'b1;
        state_nxt  = sts.eligible ? ST_LOOK_B : ST_FINISH;
      end
      ST_LOOK_B: begin
        cmd.look_b = 1'b1;
        state_nxt  = ST_COMPARE;
      end
      ST_COMPARE: begin
        cmd.compare = 1'b1;
        state_nxt   = sts.differ ? ST_SWEEP : ST_FINISH;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the result register is free
        cmd.finish = sts.out_free;
        if (sts.out_free) begin
          state_nxt = sts.last_edge ? ST_INIT : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
    // a register write restarts the label initialisation
    if (cfg_we) begin
      state_nxt = ST_INIT;
    end
  end

endmodule
`default_nettype wire

>>> rtl/kemu_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Kruskal edge merge unit - datapath
// Label memory, edge register, component count, weight total and result beat.
// ----------------------------------------------------------------------------
module kemu_dp #(
  parameter int MAX_NODES   = kemu_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = kemu_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire kemu_pkg::in_beat_t                   in_data,
  input  wire logic                                 cfg_we,
  input  wire logic [kemu_pkg::NODE_FIELD_W-1:0]    cfg_wdata,
  input  wire logic                                 out_stall,
  input  wire kemu_pkg::kemu_cmd_t                  cmd,
  output kemu_pkg::kemu_sts_t                       sts,
  output logic                                      out_valid,
  output kemu_pkg::out_beat_t                       out_data
);

  import kemu_pkg::*;

  localparam int NODE_W = $clog2(MAX_NODES + 1);
  localparam int ADDR_W = $clog2(MAX_NODES);
  localparam int CW     = (NODE_W > NODE_FIELD_W) ? NODE_W : NODE_FIELD_W;

  localparam logic [WEIGHT_FIELD_W-1:0] WMASK =
    (WEIGHT_BITS >= WEIGHT_FIELD_W) ? '1 :
    WEIGHT_FIELD_W'((64'd1 << WEIGHT_BITS) - 64'd1);

  localparam int N_RST_I = (int'(NODE_COUNT_RST) > MAX_NODES) ? MAX_NODES
                                                              : int'(NODE_COUNT_RST);
  localparam logic [NODE_W-1:0] N_RST    = NODE_W'(N_RST_I);
  localparam logic              DONE_RST = (N_RST_I <= 1);

  // Clamp a written node count to 1..MAX_NODES
  function automatic logic [NODE_W-1:0] clamp_nodes(input logic [NODE_FIELD_W-1:0] v);
    logic [CW-1:0] ve;
    ve = CW'(v);
    if (v == '0) begin
      return NODE_W'(1);
    end else if (ve > CW'(MAX_NODES)) begin
      return NODE_W'(MAX_NODES);
    end else begin
      return NODE_W'(ve);
    end
  endfunction

  // Registers
  in_beat_t          item_r, item_nxt;
  logic [NODE_W-1:0] p_r, p_nxt;
  logic [NODE_W-1:0] q_r, q_nxt;
  logic [NODE_W-1:0] n_r, n_nxt;
  logic [NODE_W-1:0] cnt_r, cnt_nxt;
  logic [NODE_W-1:0] comps_r, comps_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              done_r, done_nxt;
  logic              sel_r, sel_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_data_r, out_data_nxt;

  // Label memory port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [NODE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [NODE_W-1:0] ram_rdata;

  // Helpers
  logic [CW-1:0]         a_e, b_e, n_e;
  logic [NODE_W-1:0]     cfg_n;
  logic [WEIGHT_FIELD_W-1:0] w_m;
  logic [SUM_W:0]        sum_ext;
  logic [SUM_W-1:0]      sum_sat, sum_new;
  logic [NODE_W-1:0]     comps_new;
  logic                  done_new, fail_new;

  kemu_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_labels (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign a_e   = CW'(item_r.node_a);
  assign b_e   = CW'(item_r.node_b);
  assign n_e   = CW'(n_r);
  assign cfg_n = clamp_nodes(cfg_wdata);

  // Status to controller
  assign sts.eligible   = !done_r && (a_e != '0) && (a_e <= n_e)
                          && (b_e != '0) && (b_e <= n_e);
  assign sts.differ     = (p_r != ram_rdata);
  assign sts.sweep_done = (cnt_r == n_r);
  assign sts.init_done  = (cnt_r == n_r - NODE_W'(1));
  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.last_edge  = item_r.last_edge;

  // Read address: endpoint lookups, else sweep position
  always_comb begin
    if (cmd.look_a) begin
      ram_raddr = ADDR_W'(a_e - CW'(1));
    end else if (cmd.look_b) begin
      ram_raddr = ADDR_W'(b_e - CW'(1));
    end else if (cnt_r < n_r) begin
      ram_raddr = cnt_r[ADDR_W-1:0];
    end else begin
      ram_raddr = '0;
    end
  end

  // Saturating total and counts after a merge
  assign w_m       = item_r.weight & WMASK;
  assign sum_ext   = {1'b0, sum_r} + (SUM_W + 1)'(w_m);
  assign sum_sat   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
  assign sum_new   = sel_r ? sum_sat : sum_r;
  assign comps_new = (sel_r && (comps_r != '0)) ? comps_r - NODE_W'(1) : comps_r;
  assign done_new  = done_r || (sel_r && (comps_new <= NODE_W'(1)));
  assign fail_new  = item_r.last_edge && !done_new;

  // Next-state logic
  always_comb begin
    item_nxt      = item_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    comps_nxt     = comps_r;
    sum_nxt       = sum_r;
    done_nxt      = done_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[ADDR_W-1:0];
    ram_wdata     = p_r;

    if (cmd.capture) begin
      item_nxt = in_data;
      sel_nxt  = 1'b0;
    end

    if (cmd.look_b) begin
      p_nxt = ram_rdata;
    end

    if (cmd.compare) begin
      q_nxt   = ram_rdata;
      cnt_nxt = '0;
      sel_nxt = (p_r != ram_rdata);
    end

    // relabel: data read last cycle belongs to entry cnt-1
    if (cmd.sweep) begin
      cnt_nxt = cnt_r + NODE_W'(1);
      if ((cnt_r != '0) && (ram_rdata == q_r)) begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(cnt_r - NODE_W'(1));
        ram_wdata = p_r;
      end
    end

    // each node labelled with its own number
    if (cmd.init) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_r[ADDR_W-1:0];
      ram_wdata = cnt_r + NODE_W'(1);
      cnt_nxt   = cnt_r + NODE_W'(1);
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // result beat and state commit
    if (cmd.finish) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.selected     = sel_r;
      out_data_nxt.total_weight = fail_new ? '0 : sum_new;
      out_data_nxt.complete     = done_new;
      out_data_nxt.failed       = fail_new;
      if (item_r.last_edge) begin
        cnt_nxt   = '0;
        comps_nxt = n_r;
        sum_nxt   = '0;
        done_nxt  = (n_r <= NODE_W'(1));
      end else begin
        comps_nxt = comps_new;
        sum_nxt   = sum_new;
        done_nxt  = done_new;
      end
    end

    if (cfg_we) begin
      n_nxt     = cfg_n;
      cnt_nxt   = '0;
      comps_nxt = cfg_n;
      sum_nxt   = '0;
      done_nxt  = (cfg_n <= NODE_W'(1));
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= N_RST;
      cnt_r       <= '0;
      comps_r     <= N_RST;
      sum_r       <= '0;
      done_r      <= DONE_RST;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      n_r         <= n_nxt;
      cnt_r       <= cnt_nxt;
      comps_r     <= comps_nxt;
      sum_r       <= sum_nxt;
      done_r      <= done_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> rtl/kemu_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Kruskal edge merge unit - port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module kemu_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire kemu_pkg::out_beat_t out_data,
  input wire logic                cfg_we
);

  // a failed beat carries no total and no completion
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.failed) |-> (!out_data.complete && out_data.total_weight == '0))
    else $error("failed beat with total or complete set");

  // one edge at a time: input closes right after an accepted beat
  a_one_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open the cycle after an accepted beat");

  // reset and register writes start the label pass
  a_init_stall: assert property (@(posedge clk)
    (!rst_n || cfg_we) |=> in_stall)
    else $error("input open right after reset or register write");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule

bind kruskal_edge_merge_unit_core kemu_chk u_chk (.*);
`default_nettype wire

>>> tb/kemu_merge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kruskal edge merge unit - result checker
// Watches the edge, result and node_count ports, keeps its own copy of the
// set labels, component count and weight total, works out the result beat for
// every accepted edge beat and compares it field by field with the result
// beats that the block hands over.
// ----------------------------------------------------------------------------
module kemu_merge_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  kemu_pkg::in_beat_t                in_data,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  kemu_pkg::out_beat_t               out_data,
  input  logic                              cfg_we,
  input  logic [kemu_pkg::NODE_FIELD_W-1:0] cfg_wdata,
  output int                                mismatches,
  output int                                outstanding
);
  import kemu_pkg::*;

  localparam int          NODES = MAX_NODES_DEF;
  localparam int unsigned WMASK = (WEIGHT_BITS_DEF >= 32) ? 32'hFFFF_FFFF :
                                  ((32'd1 << WEIGHT_BITS_DEF) - 32'd1);

  // Shadow of the block state
  logic [NODE_FIELD_W-1:0] node_count_r;
  int unsigned             label_r [0:NODES];
  int unsigned             comps_left;
  logic [SUM_W-1:0]        weight_sum_r;
  logic                    tree_done_r;

  out_beat_t   merge_results_q [$];
  int unsigned err_cnt;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    err_cnt     = 0;
  end

  // Out-of-range counts are clamped to 1..NODES
  function automatic int unsigned live_nodes(input logic [NODE_FIELD_W-1:0] cnt);
    if (cnt == '0) return 1;
    if (cnt > NODES) return NODES;
    return cnt;
  endfunction

  // Fresh graph: every node its own set
  task automatic restart_graph();
    int i;
    for (i = 0; i <= NODES; i++) label_r[i] = i;
    comps_left   = live_nodes(node_count_r);
    weight_sum_r = '0;
    tree_done_r  = (comps_left <= 1);
  endtask

  // Apply one edge to the label sets and build its result beat
  task automatic merge_edge(input in_beat_t e, output out_beat_t r);
    int unsigned     n, a, b, p, q, i;
    longint unsigned s;
    logic            sel;
    n   = live_nodes(node_count_r);
    a   = e.node_a;
    b   = e.node_b;
    sel = 1'b0;
    if (!tree_done_r && a >= 1 && a <= n && b >= 1 && b <= n) begin
      p = label_r[a];
      q = label_r[b];
      if (p != q) begin
        // relabel the second set into the first
        for (i = 1; i <= n; i++) if (label_r[i] == q) label_r[i] = p;
        s = longint'(weight_sum_r) + (e.weight & WMASK);
        weight_sum_r = (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
        if (comps_left > 0) comps_left--;
        if (comps_left <= 1) tree_done_r = 1'b1;
        sel = 1'b1;
      end
    end
    r.selected     = sel;
    r.complete     = tree_done_r;
    r.failed       = e.last_edge && !tree_done_r;
    r.total_weight = r.failed ? '0 : weight_sum_r;
    if (e.last_edge) restart_graph();
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v, got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      err_cnt++;
    end
  endtask

  // Beat monitor: results are retired before new edges are predicted
  always @(posedge clk) begin : watch
    out_beat_t want, got;
    if (!rst_n) begin
      node_count_r = NODE_COUNT_RST;
      restart_graph();
      merge_results_q.delete();
    end else begin
      if (cfg_we) begin
        node_count_r = cfg_wdata;
        restart_graph();
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (merge_results_q.size() == 0) begin
          $error("result beat with no edge outstanding: %h", got);
          err_cnt++;
        end else begin
          want = merge_results_q.pop_front();
          check_field("selected", want.selected, got.selected);
          check_field("total_weight", want.total_weight, got.total_weight);
          check_field("complete", want.complete, got.complete);
          check_field("failed", want.failed, got.failed);
        end
      end
      if (in_valid && !in_stall) begin
        merge_edge(in_data, want);
        merge_results_q.push_back(want);
      end
    end
    outstanding <= merge_results_q.size();
    mismatches  <= err_cnt;
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kruskal edge merge unit - testbench top
// Drives sorted edge streams for many graphs of varying node count, with
// random sender gaps and receiver stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import kemu_pkg::*;

  // Cycles to let a last edge's label re-init finish before a node_count write
  localparam int SETTLE      = 300;
  localparam int ITEM_TARGET = 1200;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  in_beat_t                in_data   = '0;
  logic                    in_stall;
  logic                    out_valid;
  out_beat_t               out_data;
  logic                    out_stall = 1'b0;
  logic                    cfg_we    = 1'b0;
  logic [NODE_FIELD_W-1:0] cfg_wdata = '0;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          mismatches;
  int          outstanding;
  int          sent      = 0;
  int unsigned cur_nodes = 128;

  always #5 clk = ~clk;

  kruskal_edge_merge_unit_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  kemu_merge_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Run limit
  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic in_beat_t make_edge(input int unsigned a, b, w, input bit last);
    in_beat_t e;
    e.node_a    = NODE_FIELD_W'(a);
    e.node_b    = NODE_FIELD_W'(b);
    e.weight    = WEIGHT_FIELD_W'(w);
    e.last_edge = last;
    return e;
  endfunction

  // One edge beat, with random idle cycles ahead of it
  task automatic send_edge(input in_beat_t e);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Hold the sender until every result has come back
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [NODE_FIELD_W-1:0] v);
    settle(SETTLE);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_nodes = (v == 0) ? 1 : (v > 128) ? 128 : v;
  endtask

  task automatic set_phase(input int k);
    case (k)
      0: begin idle_pct = 0;  stall_pct <= 0;  end
      1: begin idle_pct = 82; stall_pct <= 0;  end
      2: begin idle_pct = 0;  stall_pct <= 82; end
      default: begin idle_pct = 31; stall_pct <= 31; end
    endcase
  endtask

  // Random spanning tree plus extra, self-loop and out-of-range edges,
  // shuffled then given non-decreasing weights; some graphs lose tree edges.
  task automatic run_graph(input int unsigned n);
    in_beat_t    graph_edges [$];
    int unsigned perm [$];
    in_beat_t    e;
    int          i, j, pause_at;
    int unsigned tmp, extra, span, w, a, b;
    bit          broken, flat;
    for (i = 1; i <= n; i++) perm.push_back(i);
    for (i = int'(n) - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
    end
    broken = ($urandom_range(99) < 15);
    for (i = 1; i < n; i++) begin
      j = $urandom_range(0, i - 1);
      if (!broken || $urandom_range(3) != 0) begin
        if ($urandom_range(1)) graph_edges.push_back(make_edge(perm[i], perm[j], 0, 0));
        else graph_edges.push_back(make_edge(perm[j], perm[i], 0, 0));
      end
    end
    extra = (n > 40) ? $urandom_range(1, 8) : $urandom_range(1, n / 2 + 2);
    for (i = 0; i < extra; i++) begin
      if ($urandom_range(99) < 15) begin
        // noise: one end outside 1..n
        a = $urandom_range(1) ? 0 : $urandom_range(n + 1, 255);
        b = $urandom_range(0, 255);
        if ($urandom_range(1)) graph_edges.push_back(make_edge(a, b, 0, 0));
        else graph_edges.push_back(make_edge(b, a, 0, 0));
      end else begin
        graph_edges.push_back(make_edge($urandom_range(1, n), $urandom_range(1, n), 0, 0));
      end
    end
    for (i = graph_edges.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      e = graph_edges[i]; graph_edges[i] = graph_edges[j]; graph_edges[j] = e;
    end
    flat = ($urandom_range(9) == 0);
    span = flat ? 0 : 65535 / graph_edges.size();
    w    = $urandom_range(0, 65535 - span * graph_edges.size());
    pause_at = ($urandom_range(7) == 0) ? graph_edges.size() / 2 : -1;
    for (i = 0; i < graph_edges.size(); i++) begin
      w = w + $urandom_range(0, span);
      e = graph_edges[i];
      e.weight    = WEIGHT_FIELD_W'(w);
      e.last_edge = (i == graph_edges.size() - 1);
      if (i == pause_at && i != 0) settle(0);
      send_edge(e);
    end
  endtask

  function automatic logic [NODE_FIELD_W-1:0] pick_node_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return NODE_FIELD_W'($urandom_range(0, 1));
    if (r < 6) return NODE_FIELD_W'($urandom_range(128, 255));
    if (r < 20) return NODE_FIELD_W'($urandom_range(13, 40));
    return NODE_FIELD_W'($urandom_range(2, 12));
  endfunction

  // Stimulus
  initial begin : stimulus
    int g;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    set_phase(0);

    // Directed: default count of 128 after reset
    send_edge(make_edge(1, 128, 0, 0));
    send_edge(make_edge(128, 1, 7, 0));      // ends already joined
    send_edge(make_edge(5, 5, 9, 0));        // self loop
    send_edge(make_edge(0, 3, 9, 0));        // end out of range
    send_edge(make_edge(3, 200, 9, 0));
    send_edge(make_edge(255, 129, 9, 0));
    send_edge(make_edge(2, 3, 65535, 0));
    send_edge(make_edge(4, 5, 65535, 1));    // last edge, tree unfinished
    // single node graph: complete from the start
    write_node_count(1);
    send_edge(make_edge(1, 1, 0, 0));
    send_edge(make_edge(1, 1, 65535, 1));
    // zero count acts as one
    write_node_count(0);
    send_edge(make_edge(1, 2, 5, 1));
    // count above the maximum acts as the maximum
    write_node_count(255);
    send_edge(make_edge(128, 127, 100, 0));
    send_edge(make_edge(127, 1, 200, 1));
    // two nodes: later edges ignored once complete
    write_node_count(2);
    send_edge(make_edge(1, 2, 100, 0));
    send_edge(make_edge(2, 1, 200, 0));
    send_edge(make_edge(1, 2, 300, 1));
    write_node_count(3);
    send_edge(make_edge(1, 2, 0, 0));
    send_edge(make_edge(3, 4, 1, 0));
    send_edge(make_edge(2, 3, 65535, 1));

    // Random graphs, rotating through the idling phases
    g = 0;
    while (sent < ITEM_TARGET) begin
      set_phase(g % 4);
      if (g == 3) write_node_count(128);
      else if (g == 0 || $urandom_range(1) == 0) write_node_count(pick_node_count());
      run_graph(cur_nodes);
      g++;
    end

    settle(SETTLE);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> kruskal_edge_merge_unit_core.f
rtl/kemu_pkg.sv
rtl/kemu_ram.sv
rtl/kemu_ctrl.sv
rtl/kemu_dp.sv
rtl/kruskal_edge_merge_unit_core.sv
rtl/kemu_chk.sv
tb/kemu_merge_checker.sv
tb/tb_top.sv
